### hw/rtl/jss_pkg.sv
// Shared types, constants and codes of the jump search table.
package jss_pkg;

  // Table geometry
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STEP_W      = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STEP   = 2'd1;

  // Request kinds
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_JUMP,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Operands of the shared add/compare unit
  typedef struct packed {
    logic [CNT_W-1:0]         op_a;
    logic [CNT_W-1:0]         op_b;
    logic signed [DATA_W-1:0] word;
    logic signed [DATA_W-1:0] key;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W:0] sum;
    logic           word_le;
    logic           word_eq;
  } alu_rsp_t;

  // Table memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

### hw/rtl/jump_search_sorted_table.sv
// Top level of the jump search table: configuration, table memory, sequencer.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o    action_i, entry_index_i, value_i
//   out      out  out_valid_o/out_ready_i  found_o, found_index_o
//   cfg      in   cfg_we_i                 cfg_index_i, cfg_data_i
//
// A load request writes the table directly.
// A search makes J jump reads (one per cycle, up to entry_count/jump_step) and a
// scan of B entries (up to jump_step), all through the single table read port.
// The table has no reset; only control state and configuration are cleared.
// A result held by out_ready_i low stalls the next search in its final state.
module jump_search_sorted_table import jss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [ADDR_W-1:0]        entry_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [ADDR_W-1:0]        found_index_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  logic [CNT_W-1:0]  entry_count_q;
  logic [STEP_W-1:0] jump_step_q;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      jump_step_q   <= STEP_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ENTRY_COUNT) begin
        entry_count_q <= cfg_data_i[CNT_W-1:0];
      end else if (cfg_index_i == CFG_JUMP_STEP) begin
        jump_step_q <= cfg_data_i[STEP_W-1:0];
      end
    end
  end

  jss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  jss_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .entry_count_i (entry_count_q),
    .jump_step_i   (jump_step_q),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata)
  );

endmodule

### hw/rtl/jss_ram.sv
// Generic single-port RAM with registered read data.
module jss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read the addressed word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hw/rtl/jss_alu.sv
// Shared adder and signed comparator used by the jump and scan steps.
module jss_alu import jss_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  // Add index operands, compare the table word against the key
  always_comb begin
    rsp_o.sum     = {1'b0, req_i.op_a} + {1'b0, req_i.op_b};
    rsp_o.word_le = (req_i.word <= req_i.key);
    rsp_o.word_eq = (req_i.word == req_i.key);
  end

endmodule

### hw/rtl/jss_seq.sv
// Search sequencer: jump phase, linear scan and result register.
module jss_seq import jss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [ADDR_W-1:0]        entry_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [ADDR_W-1:0]        found_index_o,
  input  logic [CNT_W-1:0]         entry_count_i,
  input  logic [STEP_W-1:0]        jump_step_i,
  output ram_req_t                 ram_req_o,
  input  logic [DATA_W-1:0]        ram_rdata_i
);

  state_e                   state_q, state_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         hi_q, hi_d;
  logic                     pend_q, pend_d;
  logic [ADDR_W-1:0]        cidx_q, cidx_d;
  logic                     rfound_q, rfound_d;
  logic [ADDR_W-1:0]        ridx_q, ridx_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;
  logic [ADDR_W-1:0]        fidx_q, fidx_d;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [CNT_W-1:0] step_ext;
  logic [CNT_W-1:0] hi_first;
  logic [CNT_W-1:0] hi_jump;
  logic             in_fire;

  jss_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // First block end and the next block end, both cut to the entry count
  assign step_ext = CNT_W'(step_q);
  assign hi_first = (step_ext > cnt_q) ? cnt_q : step_ext;
  assign hi_jump  = (alu_rsp.sum >= {1'b0, cnt_q}) ? cnt_q : alu_rsp.sum[CNT_W-1:0];
  assign in_fire  = in_valid_i && in_ready_o;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = pend_q;
    cidx_d      = cidx_q;
    rfound_d    = rfound_q;
    ridx_d      = ridx_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    out_valid_d = out_valid_q;

    // Drop the result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && action_i == ACTION_SEARCH) begin
          key_d   = value_i;
          cnt_d   = (entry_count_i > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : entry_count_i;
          step_d  = (jump_step_i == '0) ? STEP_W'(1) : jump_step_i;
          state_d = ST_START;
        end
      end
      ST_START: begin
        lo_d   = '0;
        pend_d = 1'b0;
        if (cnt_q == '0) begin
          rfound_d = 1'b0;
          ridx_d   = '0;
          state_d  = ST_DONE;
        end else if (hi_first < cnt_q) begin
          hi_d    = hi_first;
          state_d = ST_JUMP;
        end else begin
          hi_d    = cnt_q;
          state_d = ST_SCAN;
        end
      end
      ST_JUMP: begin
        pend_d = 1'b0;
        if (alu_rsp.word_le) begin
          lo_d = hi_q;
          hi_d = hi_jump;
          if (hi_jump >= cnt_q) begin
            state_d = ST_SCAN;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q && alu_rsp.word_eq) begin
          rfound_d = 1'b1;
          ridx_d   = cidx_q;
          state_d  = ST_DONE;
        end else if (lo_q < hi_q) begin
          pend_d = 1'b1;
          cidx_d = lo_q[ADDR_W-1:0];
          lo_d   = alu_rsp.sum[CNT_W-1:0];
        end else begin
          rfound_d = 1'b0;
          ridx_d   = '0;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = rfound_q;
          fidx_d      = ridx_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory address, shared unit operands and handshake outputs
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = entry_index_i;
    ram_req_o.wdata = value_i;
    alu_req.op_a    = hi_q;
    alu_req.op_b    = step_ext;
    alu_req.word    = ram_rdata_i;
    alu_req.key     = key_q;

    case (state_q)
      ST_IDLE: begin
        ram_req_o.we = in_fire && (action_i == ACTION_LOAD);
      end
      ST_START: begin
        ram_req_o.addr = hi_first[ADDR_W-1:0];
      end
      ST_JUMP: begin
        ram_req_o.addr = hi_jump[ADDR_W-1:0];
      end
      ST_SCAN: begin
        alu_req.op_a   = lo_q;
        alu_req.op_b   = CNT_W'(1);
        ram_req_o.addr = lo_q[ADDR_W-1:0];
      end
      ST_DONE: begin
        ram_req_o.addr = entry_index_i;
      end
      default: begin
        ram_req_o.addr = entry_index_i;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign found_index_o = fidx_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    cnt_q    <= cnt_d;
    step_q   <= step_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    cidx_q   <= cidx_d;
    rfound_q <= rfound_d;
    ridx_q   <= ridx_d;
    found_q  <= found_d;
    fidx_q   <= fidx_d;
  end

`ifndef NO_ASSERTIONS
  a_jump_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_JUMP) |-> (hi_q < cnt_q))
    else $error("jump block end outside the table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (lo_q <= hi_q && hi_q <= cnt_q))
    else $error("scan pointer past block end");

  a_match_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && rfound_q) |-> ({1'b0, ridx_q} < cnt_q))
    else $error("match index outside the table");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACTION_SEARCH) |=> !in_ready_o)
    else $error("new request taken during a search");
`endif

endmodule

### tb/sv/jump_search_sorted_table_test.sv
// Self-checking regression bench for the jump search table: loads, searches and config.
module jump_search_sorted_table_test;
  import jss_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned CFG_SETTLE   = 16;
  localparam int unsigned FINAL_SETTLE = 100;
  localparam int unsigned HOLD_LENGTH  = 400;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] index;
  } lookup_t;

  typedef enum int {FILL_DENSE, FILL_SPREAD, FILL_RANDOM} fill_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     action_i;
  logic [ADDR_W-1:0]        entry_index_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     found_o;
  logic [ADDR_W-1:0]        found_index_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  // Mirror of the table contents and register values
  logic signed [DATA_W-1:0] table_model [MAX_ENTRIES];
  logic [CNT_W-1:0]         model_count;
  logic [STEP_W-1:0]        model_step;
  lookup_t                  pending_lookups [$];
  lookup_t                  next_lookup;

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned requests_sent = 0;
  int unsigned hold_cycles   = 0;
  int unsigned stall_left    = 0;
  bit          quiet_sender   = 1'b0;
  bit          quiet_receiver = 1'b0;

  jump_search_sorted_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("jump_search_sorted_table regression: fail");
      $finish;
    end
  end

  // Jump through the table by blocks, then scan the chosen block
  function automatic lookup_t predict_lookup(input logic signed [DATA_W-1:0] key);
    lookup_t     res;
    int unsigned n, stride, lo, hi, i;
    res = '0;
    n = (model_count > MAX_ENTRIES) ? MAX_ENTRIES : model_count;
    stride = (model_step == 0) ? 1 : model_step;
    if (n == 0) return res;
    lo = 0;
    hi = (stride > n) ? n : stride;
    while (hi < n && table_model[hi] <= key) begin
      lo = hi;
      hi = (hi + stride >= n) ? n : hi + stride;
    end
    for (i = lo; i < hi; i++) begin
      if (table_model[i] == key) begin
        res.found = 1'b1;
        res.index = i[ADDR_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly hit a stored value, sometimes a neighbor, sometimes anything
  function automatic logic signed [DATA_W-1:0] pick_key(input int unsigned n);
    logic signed [DATA_W-1:0] k;
    int unsigned              r;
    r = $urandom_range(0, 9);
    if (n == 0 || r == 9) return $urandom();
    k = table_model[$urandom_range(0, n - 1)];
    if (r == 7) k = k + 1;
    else if (r == 8) k = k - 1;
    return k;
  endfunction

  // Write one register; call only while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENTRY_COUNT: model_count = data[CNT_W-1:0];
      CFG_JUMP_STEP:   model_step = data[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Write the step with junk in the unused upper bits
  task automatic write_step(input int unsigned stride);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom());
    word[STEP_W-1:0] = STEP_W'(stride);
    write_register(CFG_JUMP_STEP, word);
  endtask

  // Offer one request, hold it until accepted, and record its effect
  task automatic send_request(input logic act, input logic [ADDR_W-1:0] idx,
                              input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    entry_index_i <= idx;
    value_i       <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (act == ACTION_LOAD) table_model[idx] = val;
    else pending_lookups.push_back(predict_lookup(val));
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic search_for(input logic signed [DATA_W-1:0] key);
    send_request(ACTION_SEARCH, ADDR_W'($urandom_range(0, MAX_ENTRIES - 1)), key);
  endtask

  // Drop valid and wait for every search result, then let the block settle
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Fill entries 0..n-1 in ascending index order
  task automatic load_table(input int unsigned n, input fill_e fill);
    longint      level;
    bit [31:0]   span;
    int unsigned i;
    span = (n < 3) ? 32'hFFFF_FFFF : 32'((64'd1 << 33) / n);
    if (fill == FILL_SPREAD)
      level = -64'sd2147483648 + longint'($urandom_range(0, span >> 1));
    else
      level = longint'($signed($urandom()));
    for (i = 0; i < n; i++) begin
      case (fill)
        FILL_RANDOM: level = longint'($signed($urandom()));
        FILL_DENSE:  if (i != 0) level += longint'($urandom_range(0, 3));
        default:     if (i != 0) level += longint'($urandom_range(0, span));
      endcase
      if (level > 64'sd2147483647) level = 64'sd2147483647;
      send_request(ACTION_LOAD, i[ADDR_W-1:0], level[DATA_W-1:0]);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: found=%0b found_index=%0d", found_o, found_index_o);
        error_count++;
      end else begin
        next_lookup = pending_lookups.pop_front();
        if (found_o !== next_lookup.found) begin
          $error("found: expected %0b, got %0b", next_lookup.found, found_o);
          error_count++;
        end
        if (found_index_o !== next_lookup.index) begin
          $error("found_index: expected %0d, got %0d", next_lookup.index, found_index_o);
          error_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!quiet_receiver && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Searches straight after reset see an empty table
  task automatic test_empty_table();
    search_for(32'sh8000_0000);
    search_for(32'sh7FFF_FFFF);
    search_for(0);
    drain(CFG_SETTLE);
  endtask

  // Eight entries with extremes and duplicates, under odd register settings
  task automatic test_small_table();
    int          vals [8] = '{32'sh8000_0000, -7, -7, 0, 5, 9, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
    int unsigned i;
    write_register(CFG_ENTRY_COUNT, 8);
    write_register(CFG_JUMP_STEP, 2);
    for (i = 0; i < 8; i++) send_request(ACTION_LOAD, i[ADDR_W-1:0], vals[i]);
    search_for(vals[0]);
    search_for(vals[7]);
    search_for(-7);
    search_for(6);
    search_for(9);
    drain(CFG_SETTLE);
    // writes to missing registers must change nothing
    write_register(CFG_SPARE_LO, 11'h7FF);
    write_register(CFG_SPARE_HI, 11'h555);
    // zero step behaves as one
    write_register(CFG_JUMP_STEP, 11'h7C0);
    search_for(5);
    drain(CFG_SETTLE);
    // step past the table end: one block
    write_register(CFG_JUMP_STEP, 11'h7E0);
    search_for(32'sh7FFF_FFFE);
    drain(CFG_SETTLE);
    write_register(CFG_JUMP_STEP, 11'h03F);
    search_for(0);
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, 1);
    search_for(vals[0]);
    search_for(0);
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, 0);
    search_for(9);
    drain(CFG_SETTLE);
  endtask

  // Phases of fresh tables, random steps and mixed searches
  task automatic test_random_tables();
    int unsigned budget_end, n, r, stride, searches;
    fill_e       fill;
    budget_end = requests_sent + RANDOM_ITEMS;
    while (requests_sent < budget_end) begin
      drain(CFG_SETTLE);
      quiet_sender   = ($urandom_range(0, 3) == 0);
      quiet_receiver = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r == 1) n = 1;
      else if (r == 2) n = $urandom_range(49, 200);
      else n = $urandom_range(2, 48);
      r = $urandom_range(0, 9);
      if (r < 5) stride = floor_sqrt(n);
      else if (r < 7) stride = $urandom_range(1, 63);
      else if (r == 7) stride = 0;
      else stride = floor_sqrt(n) + 1;
      write_register(CFG_ENTRY_COUNT, n);
      write_step(stride);
      r = $urandom_range(0, 9);
      fill = (r < 4) ? FILL_DENSE : (r < 8) ? FILL_SPREAD : FILL_RANDOM;
      load_table(n, fill);
      searches = $urandom_range(8, 30);
      repeat (searches) begin
        // stray loads anywhere in the table now and then
        if ($urandom_range(0, 9) == 0)
          send_request(ACTION_LOAD, ADDR_W'($urandom_range(0, MAX_ENTRIES - 1)),
                       $urandom());
        else
          search_for(pick_key(n));
      end
    end
    drain(CFG_SETTLE);
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // Whole table, result side held back, oversized count and extreme steps
  task automatic test_full_table_pressure();
    write_register(CFG_ENTRY_COUNT, MAX_ENTRIES);
    write_step(floor_sqrt(MAX_ENTRIES));
    load_table(MAX_ENTRIES, FILL_SPREAD);
    repeat (20) search_for(pick_key(MAX_ENTRIES));
    // keep offering searches while results are held off
    quiet_sender = 1'b1;
    hold_cycles  = HOLD_LENGTH;
    repeat (12) search_for(pick_key(MAX_ENTRIES));
    quiet_sender = 1'b0;
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, 11'h7FF);
    write_step(0);
    repeat (3) search_for(pick_key(MAX_ENTRIES));
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, MAX_ENTRIES + 1);
    write_step(63);
    repeat (6) search_for(pick_key(MAX_ENTRIES));
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, 1000);
    write_step(floor_sqrt(1000));
    repeat (10) search_for(pick_key(1000));
    drain(CFG_SETTLE);
    write_register(CFG_ENTRY_COUNT, MAX_ENTRIES);
    write_step(1);
    repeat (2) search_for(pick_key(MAX_ENTRIES));
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACTION_LOAD;
    entry_index_i = '0;
    value_i       = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ENTRY_COUNT;
    cfg_data_i    = '0;
    model_count   = '0;
    model_step    = STEP_W'(1);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_small_table();
    test_random_tables();
    test_full_table_pressure();

    drain(FINAL_SETTLE);
    if (error_count == 0) begin
      $display("jump_search_sorted_table regression: pass");
    end else begin
      $display("jump_search_sorted_table regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/jss_pkg.sv
hw/rtl/jss_ram.sv
hw/rtl/jss_alu.sv
hw/rtl/jss_seq.sv
hw/rtl/jump_search_sorted_table.sv
tb/sv/jump_search_sorted_table_test.sv
